FILE: sv/lsfs_pkg.sv
// shared types, constants and colour packing for the led strip frame serializer
package lsfs_pkg;

  localparam int MAX_LEDS_DEF   = 256;
  localparam int LATCH_BITS_DEF = 24;
  localparam int PIXEL_W        = 24;
  localparam int LED_COUNT_W    = 9;
  localparam int CFG_ADDR_W     = 3;
  localparam int CFG_DATA_W     = 32;

  localparam logic [7:0] COLOUR_MARK = 8'h80;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_FILL  = 2'd1,
    OP_START = 2'd2,
    OP_TICK  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_LED_COUNT = 1'b0
  } reg_idx_t;

  typedef enum logic [2:0] {
    SEC_LEAD   = 3'b001,
    SEC_PIXELS = 3'b010,
    SEC_TRAIL  = 3'b100
  } section_t;

  typedef enum logic [2:0] {
    MODE_CLEAR = 3'b001,
    MODE_IDLE  = 3'b010,
    MODE_FILL  = 3'b100
  } mode_t;

  // green in the top byte, then red, then blue, each with bit 7 set
  function automatic logic [PIXEL_W-1:0] pack_grb(input logic [7:0] r, input logic [7:0] g,
                                                   input logic [7:0] b);
    pack_grb = {g | COLOUR_MARK, r | COLOUR_MARK, b | COLOUR_MARK};
  endfunction

endpackage

FILE: sv/led_strip_frame_serializer.sv
// led strip frame serializer: pixel store, fill walker and serial frame generator
//
// usage
//   a command word is taken at a rising edge with start high and busy low. in_operation picks
//   write pixel, fill all, start frame or bit tick; the colour and index ports go with it.
//   a write, fill or start during a frame is dropped, as is a write whose index is not below
//   the active led count (led_count clamped to MAX_LEDS).
//   each bit tick during a frame gives one result word: out_valid is high for exactly one cycle,
//   the cycle after the tick is taken, with out_data_bit and out_frame_last. the frame is
//   LATCH_BITS zero bits, 24 bits per active pixel msb first, then LATCH_BITS zero bits, the
//   final one flagged by out_frame_last. the receiver cannot stall: a result word is gone
//   after its cycle.
// throughput
//   write, start and tick are taken back to back. a fill walks the pixel store
//   through its single write port, one entry a cycle, with busy high until every
//   active entry is written. the pixel word for the current position is read ahead,
//   so ticks run every cycle.
// reset
//   rst_n is synchronous. after reset the store is cleared by a pass over all MAX_LEDS
//   entries with busy high; apb writes of led_count are taken throughout.
// configuration
//   apb register at byte 0: led_count, 9 bits. pready is tied high.
module led_strip_frame_serializer #(
  parameter int MAX_LEDS   = lsfs_pkg::MAX_LEDS_DEF,
  parameter int LATCH_BITS = lsfs_pkg::LATCH_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // command channel
  input  logic                                 start,
  output logic                                 busy,
  input  lsfs_pkg::op_t                        in_operation,
  input  logic [7:0]                           in_pixel_index,
  input  logic [7:0]                           in_red,
  input  logic [7:0]                           in_green,
  input  logic [7:0]                           in_blue,
  // result channel
  output logic                                 out_valid,
  output logic                                 out_data_bit,
  output logic                                 out_frame_last,
  // apb configuration
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [lsfs_pkg::CFG_ADDR_W-1:0]      paddr,
  input  logic [lsfs_pkg::CFG_DATA_W-1:0]      pwdata,
  output logic [lsfs_pkg::CFG_DATA_W-1:0]      prdata,
  output logic                                 pready
);
  import lsfs_pkg::*;

  // widths that follow from the store depth and latch length
  localparam int CNT_W  = $clog2(MAX_LEDS + 1);
  localparam int AW     = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CMP_W  = (CNT_W > LED_COUNT_W) ? CNT_W : LED_COUNT_W;
  localparam int IDX_W  = (CNT_W > 8) ? CNT_W : 8;
  localparam int BP_MAX = (LATCH_BITS > PIXEL_W) ? LATCH_BITS : PIXEL_W;
  localparam int BP_W   = $clog2(BP_MAX);

  // pixel store: one write port, one registered read port
  logic [PIXEL_W-1:0] mem [MAX_LEDS];
  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [PIXEL_W-1:0] mem_wdata;
  logic [AW-1:0]      rd_addr;
  logic [PIXEL_W-1:0] rd_word_r;

  // control state
  mode_t              mode_r, mode_nxt;
  logic [CNT_W-1:0]   walk_addr_r, walk_addr_nxt;
  logic [PIXEL_W-1:0] fill_word_r, fill_word_nxt;
  logic               frame_active_r, frame_active_nxt;
  section_t           sec_r, sec_nxt;
  logic [BP_W-1:0]    bp_r, bp_nxt;
  logic [CNT_W-1:0]   pp_r, pp_nxt;
  logic [LED_COUNT_W-1:0] led_count_r;
  logic               out_valid_r, out_valid_nxt;
  logic               out_data_bit_r, out_data_bit_nxt;
  logic               out_frame_last_r, out_frame_last_nxt;

  // helpers
  logic               accept;
  logic               cfg_wr;
  logic [CNT_W-1:0]   active_cnt;
  logic [PIXEL_W-1:0] in_word;
  logic               idx_ok;
  section_t           sec_eff;
  logic [BP_W-1:0]    bp_eff;
  logic [BP_W:0]      bp_inc;
  logic [CNT_W:0]     walk_inc;
  logic [4:0]         pix_sel;

  assign busy   = (mode_r != MODE_IDLE);
  assign accept = start && !busy;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  // led_count above the store depth acts as the depth
  assign active_cnt = (CMP_W'(led_count_r) > CMP_W'(MAX_LEDS)) ? CNT_W'(MAX_LEDS)
                                                                : CNT_W'(led_count_r);
  assign in_word  = pack_grb(in_red, in_green, in_blue);
  assign idx_ok   = IDX_W'(in_pixel_index) < IDX_W'(active_cnt);
  assign walk_inc = {1'b0, walk_addr_r} + 1'b1;

  // a pixel section whose position has run past the count drops straight to the trailer
  assign sec_eff = (sec_r == SEC_PIXELS && pp_r >= active_cnt) ? SEC_TRAIL : sec_r;
  assign bp_eff  = (sec_r == SEC_PIXELS && pp_r >= active_cnt) ? '0 : bp_r;
  assign bp_inc  = {1'b0, bp_eff} + 1'b1;
  assign pix_sel = 5'(PIXEL_W - 1) - bp_eff[4:0];

  always_comb begin
    mode_nxt           = mode_r;
    walk_addr_nxt      = walk_addr_r;
    fill_word_nxt      = fill_word_r;
    frame_active_nxt   = frame_active_r;
    sec_nxt            = sec_r;
    bp_nxt             = bp_r;
    pp_nxt             = pp_r;
    out_valid_nxt      = 1'b0;
    out_data_bit_nxt   = 1'b0;
    out_frame_last_nxt = 1'b0;
    mem_we             = 1'b0;
    mem_waddr          = walk_addr_r[AW-1:0];
    mem_wdata          = fill_word_r;

    case (mode_r)
      MODE_CLEAR: begin
        mem_we    = 1'b1;
        mem_wdata = '0;
        walk_addr_nxt = walk_inc[CNT_W-1:0];
        if (walk_addr_r == CNT_W'(MAX_LEDS - 1)) begin
          mode_nxt      = MODE_IDLE;
          walk_addr_nxt = '0;
        end
      end
      MODE_FILL: begin
        mem_we        = 1'b1;
        walk_addr_nxt = walk_inc[CNT_W-1:0];
        if (walk_inc >= {1'b0, active_cnt}) begin
          mode_nxt      = MODE_IDLE;
          walk_addr_nxt = '0;
        end
      end
      MODE_IDLE: begin
        if (accept) begin
          case (in_operation)
            OP_WRITE: begin
              if (!frame_active_r && idx_ok) begin
                mem_we    = 1'b1;
                mem_waddr = IDX_W'(in_pixel_index) < IDX_W'(MAX_LEDS)
                          ? AW'(in_pixel_index) : '0;
                mem_wdata = in_word;
              end
            end
            OP_FILL: begin
              if (!frame_active_r && active_cnt != '0) begin
                mode_nxt      = MODE_FILL;
                walk_addr_nxt = '0;
                fill_word_nxt = in_word;
              end
            end
            OP_START: begin
              if (!frame_active_r) begin
                frame_active_nxt = 1'b1;
                sec_nxt          = SEC_LEAD;
                bp_nxt           = '0;
                pp_nxt           = '0;
              end
            end
            OP_TICK: begin
              if (frame_active_r) begin
                out_valid_nxt = 1'b1;
                sec_nxt       = sec_eff;
                case (sec_eff)
                  SEC_LEAD: begin
                    bp_nxt = bp_inc[BP_W-1:0];
                    if (bp_inc >= (BP_W+1)'(LATCH_BITS)) begin
                      sec_nxt = SEC_PIXELS;
                      bp_nxt  = '0;
                      pp_nxt  = '0;
                    end
                  end
                  SEC_PIXELS: begin
                    out_data_bit_nxt = rd_word_r[pix_sel];
                    bp_nxt = bp_inc[BP_W-1:0];
                    if (bp_inc >= (BP_W+1)'(PIXEL_W)) begin
                      bp_nxt = '0;
                      pp_nxt = pp_r + 1'b1;
                    end
                  end
                  SEC_TRAIL: begin
                    bp_nxt = bp_inc[BP_W-1:0];
                    if (bp_inc >= (BP_W+1)'(LATCH_BITS)) begin
                      out_frame_last_nxt = 1'b1;
                      frame_active_nxt   = 1'b0;
                      sec_nxt            = SEC_LEAD;
                      bp_nxt             = '0;
                      pp_nxt             = '0;
                    end
                  end
                  default: begin
                    sec_nxt = SEC_LEAD;
                  end
                endcase
              end
            end
            default: begin
              mode_nxt = mode_r;
            end
          endcase
        end
      end
      default: begin
        mode_nxt = MODE_CLEAR;
      end
    endcase
  end

  // read ahead at the next pixel position; the store is never written during a
  // frame, and start rereads entry zero so a write just before it is seen
  assign rd_addr = pp_nxt[AW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_word_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_CLEAR;
      walk_addr_r    <= '0;
      frame_active_r <= 1'b0;
      sec_r          <= SEC_LEAD;
      bp_r           <= '0;
      pp_r           <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      mode_r         <= mode_nxt;
      walk_addr_r    <= walk_addr_nxt;
      frame_active_r <= frame_active_nxt;
      sec_r          <= sec_nxt;
      bp_r           <= bp_nxt;
      pp_r           <= pp_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    fill_word_r      <= fill_word_nxt;
    out_data_bit_r   <= out_data_bit_nxt;
    out_frame_last_r <= out_frame_last_nxt;
  end

  // apb register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_count_r <= '0;
    end else if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_LED_COUNT) begin
      led_count_r <= pwdata[LED_COUNT_W-1:0];
    end
  end

  assign prdata = (paddr[CFG_ADDR_W-1] == REG_LED_COUNT) ? CFG_DATA_W'(led_count_r) : '0;

  assign out_valid      = out_valid_r;
  assign out_data_bit   = out_data_bit_r;
  assign out_frame_last = out_frame_last_r;

  // a result word follows only a tick taken during a frame
  a_result_from_tick: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept && in_operation == OP_TICK && frame_active_r))
    else $error("result word without a tick in a frame");

  // the last bit closes the frame
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_last) |-> !frame_active_r)
    else $error("frame still active after its last bit");

  // the store is never written while a frame is being sent
  a_no_write_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !frame_active_r)
    else $error("pixel store written during a frame");

  // clear and fill walks never overlap a frame
  a_walk_not_in_frame: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !frame_active_r)
    else $error("store walk during a frame");

endmodule

FILE: verif/led_strip_frame_serializer_tb.sv
`timescale 1ns / 100ps
// self-checking testbench for the led strip frame serializer: directed table, random phases
module led_strip_frame_serializer_tb;
  import lsfs_pkg::*;

  localparam int WATCHDOG_LIMIT  = 3000;
  localparam int TABLE_ROWS      = 25;
  localparam int PHASES          = 12;
  localparam int ITEMS_PER_PHASE = 90;
  localparam int DRAIN_CYCLES    = 4;
  localparam int REPORT_LIMIT    = 40;

  // a directed row either sends a command word (possibly repeated) or rewrites led_count
  typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;
  // typed expectation of a row; EXP_PREDICT leaves the answer to the predictor
  typedef enum logic [1:0] {EXP_PREDICT, EXP_QUIET, EXP_LOW, EXP_LAST} row_exp_t;

  typedef struct {
    row_kind_t  kind;
    op_t        op;
    logic [7:0] idx;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    int         reps;
    logic [8:0] count;
    row_exp_t   want;
  } dir_row_t;

  typedef struct packed {
    logic data_bit;
    logic frame_last;
  } serial_bit_t;

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  // command channel, every input known from time zero
  logic       start          = 1'b0;
  logic       busy;
  op_t        in_operation   = OP_WRITE;
  logic [7:0] in_pixel_index = '0;
  logic [7:0] in_red         = '0;
  logic [7:0] in_green       = '0;
  logic [7:0] in_blue        = '0;

  // result channel
  logic out_valid;
  logic out_data_bit;
  logic out_frame_last;

  // apb side
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr   = '0;
  logic [CFG_DATA_W-1:0] pwdata  = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  // predictor copy of the strip: pixel store, frame walker and led_count
  logic [PIXEL_W-1:0] strip_mem [MAX_LEDS_DEF];
  logic               frame_on   = 1'b0;
  section_t           frame_sect = SEC_LEAD;
  int                 frame_bit  = 0;
  int                 frame_pix  = 0;
  logic [8:0]         led_cfg    = '0;

  // serial bits still owed by the block, oldest first
  serial_bit_t bits_due [$];

  // bookkeeping
  int gap_pct       = 0;
  int mismatches    = 0;
  int words_taken   = 0;
  int bits_checked  = 0;
  int frames_closed = 0;
  int reg_writes    = 0;
  int quiet_cycles  = 0;

  dir_row_t dir_rows [TABLE_ROWS];
  int       count_plan [PHASES] = '{3, 0, 511, 1, 2, 256, 5, 1, 300, 4, 2, 0};
  int       gap_plan [3]        = '{0, 83, 18};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  led_strip_frame_serializer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_operation   (in_operation),
    .in_pixel_index (in_pixel_index),
    .in_red         (in_red),
    .in_green       (in_green),
    .in_blue        (in_blue),
    .out_valid      (out_valid),
    .out_data_bit   (out_data_bit),
    .out_frame_last (out_frame_last),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // what the strip does with one accepted command word; got is set when a serial bit comes out
  task automatic predict_serial_out(input op_t op, input logic [7:0] idx, input logic [7:0] r,
                                    input logic [7:0] g, input logic [7:0] b,
                                    output logic got, output serial_bit_t res);
    int                 lim;
    int                 i;
    logic [PIXEL_W-1:0] colour;
    // a count above the store behaves as a full store
    lim    = (int'(led_cfg) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(led_cfg);
    colour = {g | COLOUR_MARK, r | COLOUR_MARK, b | COLOUR_MARK};
    got    = 1'b0;
    res    = '0;
    case (op)
      OP_WRITE: begin
        if (!frame_on && int'(idx) < lim) strip_mem[idx] = colour;
      end
      OP_FILL: begin
        if (!frame_on)
          for (i = 0; i < lim; i++) strip_mem[i] = colour;
      end
      OP_START: begin
        if (!frame_on) begin
          frame_on   = 1'b1;
          frame_sect = SEC_LEAD;
          frame_bit  = 0;
          frame_pix  = 0;
        end
      end
      default: begin
        // bit tick: silent unless a frame is running
        if (frame_on) begin
          got = 1'b1;
          // a shrunk count cuts the pixel section short
          if (frame_sect == SEC_PIXELS && frame_pix >= lim) begin
            frame_sect = SEC_TRAIL;
            frame_bit  = 0;
          end
          case (frame_sect)
            SEC_LEAD: begin
              frame_bit++;
              if (frame_bit >= LATCH_BITS_DEF) begin
                frame_sect = SEC_PIXELS;
                frame_bit  = 0;
                frame_pix  = 0;
              end
            end
            SEC_PIXELS: begin
              res.data_bit = strip_mem[frame_pix][PIXEL_W-1-frame_bit];
              frame_bit++;
              if (frame_bit >= PIXEL_W) begin
                frame_bit = 0;
                frame_pix++;
              end
            end
            default: begin
              frame_bit++;
              if (frame_bit >= LATCH_BITS_DEF) begin
                res.frame_last = 1'b1;
                frame_on       = 1'b0;
                frame_sect     = SEC_LEAD;
                frame_bit      = 0;
                frame_pix      = 0;
              end
            end
          endcase
        end
      end
    endcase
  endtask

  // offer one command word, with a random gap first, and return at the edge that takes it;
  // start is left high so a following word can go back to back
  task automatic send_word(input op_t op, input logic [7:0] idx, input logic [7:0] r,
                           input logic [7:0] g, input logic [7:0] b,
                           output logic got, output serial_bit_t res);
    while (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start          <= 1'b1;
    in_operation   <= op;
    in_pixel_index <= idx;
    in_red         <= r;
    in_green       <= g;
    in_blue        <= b;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    words_taken++;
    predict_serial_out(op, idx, r, g, b, got, res);
  endtask

  // rewrite led_count once the strip has gone quiet, then read it back
  task automatic apply_led_count(input logic [8:0] val);
    start <= 1'b0;
    while (bits_due.size() != 0) @(posedge clk);
    // a fill or write gives no result word, so let busy settle before touching the register
    repeat (2) @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    repeat (2) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= CFG_ADDR_W'(4 * REG_LED_COUNT);
    pwdata  <= CFG_DATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    led_cfg = val;
    reg_writes++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (pready !== 1'b1) @(posedge clk);
    if (prdata !== CFG_DATA_W'(val)) begin
      mismatches++;
      $display("%0t: led_count readback expected %0d got %0d", $time, val, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result side: every strobed word is matched against the oldest bit owed
  always @(posedge clk) begin
    serial_bit_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (bits_due.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: result word with nothing due, expected none got data_bit %b last %b",
                   $time, out_data_bit, out_frame_last);
      end else begin
        want = bits_due.pop_front();
        bits_checked++;
        if (want.frame_last) frames_closed++;
        if (out_data_bit !== want.data_bit) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: data_bit expected %b got %b", $time, want.data_bit, out_data_bit);
        end
        if (out_frame_last !== want.frame_last) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: frame_last expected %b got %b", $time, want.frame_last,
                     out_frame_last);
        end
      end
    end
  end

  // watchdog: any taken word, result word or register write counts as progress
  always @(posedge clk) begin
    if (!rst_n || (start && busy === 1'b0) || out_valid === 1'b1 || (psel && penable && pwrite))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: watchdog, %0d cycles without progress, %0d bits still due", $time,
               quiet_cycles, bits_due.size());
      $display("led_strip_frame_serializer regression: fail");
      $finish;
    end
  end

  initial begin
    dir_row_t    row;
    logic        got;
    serial_bit_t res;
    int          lim;
    int          pick;
    int          n;
    op_t         op;
    logic [7:0]  idx;

    foreach (strip_mem[i]) strip_mem[i] = '0;

    // directed table: idle tick, busy drops, empty strip, clamped count, out of range write,
    // a short frame read back bit by bit, and a count cut while the pixels are going out
    dir_rows = '{
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_START, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_WRITE, 8'h00, 8'hff, 8'hff, 8'hff,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_FILL,  8'h00, 8'h00, 8'hff, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_START, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 47, 9'd0,   EXP_LOW},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_LAST},
      '{ROW_REG, OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd300, EXP_QUIET},
      '{ROW_CMD, OP_FILL,  8'h00, 8'h55, 8'haa, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_WRITE, 8'hff, 8'hff, 8'hff, 8'hff,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_REG, OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd2,   EXP_QUIET},
      '{ROW_CMD, OP_WRITE, 8'h02, 8'h12, 8'h34, 8'h56,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_WRITE, 8'h01, 8'h7f, 8'h01, 8'hfe,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_START, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 24, 9'd0,   EXP_LOW},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 48, 9'd0,   EXP_PREDICT},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 23, 9'd0,   EXP_LOW},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_LAST},
      '{ROW_REG, OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd256, EXP_QUIET},
      '{ROW_CMD, OP_START, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_QUIET},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 53, 9'd0,   EXP_PREDICT},
      '{ROW_REG, OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd1,   EXP_QUIET},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00, 23, 9'd0,   EXP_LOW},
      '{ROW_CMD, OP_TICK,  8'h00, 8'h00, 8'h00, 8'h00,  1, 9'd0,   EXP_LAST}
    };

    // synchronous reset held, then released; the clearing pass afterwards shows up as busy
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      if (row.kind == ROW_REG) begin
        apply_led_count(row.count);
      end else begin
        for (n = 0; n < row.reps; n++) begin
          send_word(row.op, row.idx, row.red, row.green, row.blue, got, res);
          case (row.want)
            EXP_PREDICT: if (got) bits_due.push_back(res);
            EXP_LOW:     bits_due.push_back(serial_bit_t'{1'b0, 1'b0});
            EXP_LAST:    bits_due.push_back(serial_bit_t'{1'b0, 1'b1});
            default:     ;
          endcase
        end
      end
    end

    // random phases: each picks a led_count and a sender gap rate; frames often run across
    // a phase boundary, so the new count lands mid-frame
    for (int p = 0; p < PHASES; p++) begin
      apply_led_count(9'(count_plan[p]));
      gap_pct = gap_plan[p % 3];
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        lim  = (int'(led_cfg) > MAX_LEDS_DEF) ? MAX_LEDS_DEF : int'(led_cfg);
        pick = $urandom_range(99);
        if (frame_on) begin
          // mostly ticks, with the odd write, fill or start that the busy frame must drop
          if (pick < 92) begin
            op = OP_TICK;
          end else begin
            case ($urandom_range(2))
              0:       op = OP_WRITE;
              1:       op = OP_FILL;
              default: op = OP_START;
            endcase
          end
        end else if (pick < 6) begin
          op = OP_TICK;
        end else if (pick < 60) begin
          op = OP_WRITE;
        end else if (pick < 68) begin
          op = OP_FILL;
        end else begin
          op = OP_START;
        end
        // indices mostly inside the strip, the rest anywhere
        if (lim > 0 && $urandom_range(99) < 85) idx = 8'($urandom_range(lim - 1));
        else idx = 8'($urandom);
        send_word(op, idx, 8'($urandom), 8'($urandom), 8'($urandom), got, res);
        if (got) bits_due.push_back(res);
      end
    end

    // drain: wait for the last owed bit, then keep watching for stray result words
    start <= 1'b0;
    while (bits_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d command words and %0d register writes over %0d count settings",
             words_taken, reg_writes, PHASES);
    $display("checked %0d serial bits, %0d frames closed, %0d mismatches",
             bits_checked, frames_closed, mismatches);
    if (mismatches == 0)
      $display("led_strip_frame_serializer regression: pass");
    else
      $display("led_strip_frame_serializer regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
sv/lsfs_pkg.sv
sv/led_strip_frame_serializer.sv
verif/led_strip_frame_serializer_tb.sv
